### sv/ikh_pkg.sv
// ----------------------------------------------------------------------------
// ikh_pkg: shared types and constants of the integer-key hash table
// Transaction payloads, command and status codes, mixer constants and the
// command/status bundles that join controller and datapath.
// ----------------------------------------------------------------------------
package ikh_pkg;

	// Default sizes
	localparam int BUCKETS_DEF = 256;
	localparam int NODES_DEF   = 192;

	// Width of one word of the free-node bitmap
	localparam int FREE_WORD_W = 32;

	// Request commands
	localparam logic [1:0] CMD_LOOKUP = 2'd0;
	localparam logic [1:0] CMD_SET    = 2'd1;
	localparam logic [1:0] CMD_DELETE = 2'd2;
	localparam logic [1:0] CMD_NONE   = 2'd3;

	// Response status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_MISSING = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	// Finalizer constants
	localparam logic [63:0] MIX_C1    = 64'hff51afd7ed558ccd;
	localparam logic [63:0] MIX_C2    = 64'hc4ceb9fe1a85ec53;
	localparam int          MIX_SHIFT = 33;

	// Datapath operations
	localparam logic [3:0] DOP_NONE      = 4'd0;
	localparam logic [3:0] DOP_CLEAR     = 4'd1;
	localparam logic [3:0] DOP_LOAD      = 4'd2;
	localparam logic [3:0] DOP_HEAD      = 4'd3;
	localparam logic [3:0] DOP_NEXT      = 4'd4;
	localparam logic [3:0] DOP_OVERWRITE = 4'd5;
	localparam logic [3:0] DOP_UNLINK    = 4'd6;
	localparam logic [3:0] DOP_INSERT    = 4'd7;
	localparam logic [3:0] DOP_ALLOC     = 4'd8;
	localparam logic [3:0] DOP_FREE      = 4'd9;
	localparam logic [3:0] DOP_SCAN_NEXT = 4'd10;
	localparam logic [3:0] DOP_SCAN_TAKE = 4'd11;

	// Free bitmap read address sources
	localparam logic [1:0] FSEL_SCAN = 2'd0;
	localparam logic [1:0] FSEL_CUR  = 2'd1;
	localparam logic [1:0] FSEL_LOW  = 2'd2;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [63:0] key;
		logic [63:0]        value;
	} req_t;

	typedef struct packed {
		logic        found;
		logic [63:0] read_value;
		logic [7:0]  stored_count;
		logic [1:0]  status;
	} rsp_t;

	typedef struct packed {
		logic [3:0] op;
		logic [1:0] fsel;
		logic       res_we;
		logic       res_found;
		logic [1:0] res_status;
		logic       res_take_val;
		logic       out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic       clr_last;
		logic       hash_done;
		logic       cur_valid;
		logic       key_match;
		logic       full;
		logic       scan_hit;
		logic [1:0] command;
	} ctl_stat_t;

endpackage

### sv/ikh_mix.sv
// ----------------------------------------------------------------------------
// ikh_mix: 64-bit finalizer hash
// Two 64x64 multiplies modulo 2^64, each built from three 32x32 partial
// products on one shared multiplier, one partial product per cycle.
// ----------------------------------------------------------------------------
module ikh_mix (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] key,
	output logic        done,
	output logic [63:0] hash
);

	logic [2:0]  step_q;
	logic        busy_q;
	logic        done_q;
	logic [63:0] x_q;
	logic [63:0] acc_q;
	logic [1:0]  sub;
	logic [63:0] cst;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [63:0] prod;
	logic [63:0] acc_new;

	always_comb begin
		case (step_q)
			3'd0, 3'd3: sub = 2'd0;
			3'd1, 3'd4: sub = 2'd1;
			default:    sub = 2'd2;
		endcase
		cst     = (step_q < 3'd3) ? ikh_pkg::MIX_C1 : ikh_pkg::MIX_C2;
		op_a    = (sub == 2'd1) ? x_q[63:32] : x_q[31:0];
		op_b    = (sub == 2'd2) ? cst[63:32] : cst[31:0];
		prod    = {32'b0, op_a} * {32'b0, op_b};
		acc_new = (sub == 2'd0) ? prod : {acc_q[63:32] + prod[31:0], acc_q[31:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			step_q <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			if (step_q == 3'd5) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				step_q <= step_q + 3'd1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= key ^ (key >> ikh_pkg::MIX_SHIFT);
		end else if (busy_q) begin
			acc_q <= acc_new;
			if (sub == 2'd2) begin
				x_q <= acc_new ^ (acc_new >> ikh_pkg::MIX_SHIFT);
			end
		end
	end

	assign done = done_q;
	assign hash = x_q;

endmodule

### sv/ikh_datapath.sv
// ----------------------------------------------------------------------------
// ikh_datapath: memories and registers of the hash table
// Bucket heads, node key/value/link stores, free-node bitmap, chain walk
// pointers, entry count and the response register.
// ----------------------------------------------------------------------------
module ikh_datapath #(
	parameter int BUCKETS = ikh_pkg::BUCKETS_DEF,
	parameter int NODES   = ikh_pkg::NODES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ikh_pkg::req_t     req,
	input  ikh_pkg::ctl_cmd_t cmd,
	output ikh_pkg::ctl_stat_t stat,
	output ikh_pkg::rsp_t     rsp
);

	localparam int BW  = $clog2(BUCKETS);
	localparam int LW  = $clog2(NODES + 1);
	localparam int NW  = $clog2(NODES);
	localparam int FW  = (NODES + ikh_pkg::FREE_WORD_W - 1) / ikh_pkg::FREE_WORD_W;
	localparam int FWW = (FW > 1) ? $clog2(FW) : 1;
	localparam int IW  = FWW + 5;
	localparam int CL  = (BUCKETS > FW) ? BUCKETS : FW;
	localparam int CW  = $clog2(CL);
	localparam logic [LW-1:0] EMPTY = {LW{1'b1}};

	// Storage
	logic [LW-1:0] bucket_mem [BUCKETS];
	logic [63:0]   key_mem    [NODES];
	logic [63:0]   val_mem    [NODES];
	logic [LW-1:0] link_mem   [NODES];
	logic [31:0]   free_mem   [FW];

	// Registers
	ikh_pkg::req_t op_q;
	logic [BW-1:0] bkt_q;
	logic [LW-1:0] cur_q;
	logic [LW-1:0] prev_q;
	logic [LW-1:0] count_q;
	logic [IW-1:0] lowfree_q;
	logic [FWW-1:0] scan_q;
	logic [CW-1:0] clr_q;
	logic          res_found_q;
	logic [1:0]    res_status_q;
	logic [63:0]   res_rd_q;
	ikh_pkg::rsp_t rsp_q;

	// Registered read data
	logic [LW-1:0] bkt_rd_q;
	logic [63:0]   key_rd_q;
	logic [63:0]   val_rd_q;
	logic [LW-1:0] link_rd_q;
	logic [31:0]   free_rd_q;

	logic          hash_done;
	logic [63:0]   hash;
	logic [NW-1:0] cur_idx;
	logic [NW-1:0] prev_idx;
	logic [NW-1:0] low_idx;
	logic [IW-1:0] cur_iw;
	logic [FWW-1:0] free_raddr;
	logic [4:0]    pe;
	logic [31:0]   clr_mask;
	logic [LW+7:0] count_ext;

	ikh_mix u_mix (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.op == ikh_pkg::DOP_LOAD),
		.key    (req.key),
		.done   (hash_done),
		.hash   (hash)
	);

	always_comb begin
		cur_idx  = cur_q[NW-1:0];
		prev_idx = prev_q[NW-1:0];
		low_idx  = lowfree_q[NW-1:0];
		cur_iw   = IW'(cur_idx);
		case (cmd.fsel)
			ikh_pkg::FSEL_CUR: free_raddr = cur_iw[IW-1:5];
			ikh_pkg::FSEL_LOW: free_raddr = lowfree_q[IW-1:5];
			default:           free_raddr = scan_q;
		endcase
		pe = 5'd0;
		for (int j = 31; j >= 0; j--) begin
			if (free_rd_q[j]) pe = 5'(j);
		end
		for (int j = 0; j < 32; j++) begin
			clr_mask[j] = (32'({clr_q[FWW-1:0], 5'(j)}) < NODES);
		end
		count_ext = {8'b0, count_q};
	end

	// Bucket heads
	always_ff @(posedge clk) begin
		if (cmd.op == ikh_pkg::DOP_CLEAR && 32'(clr_q) < BUCKETS) begin
			bucket_mem[clr_q[BW-1:0]] <= EMPTY;
		end else if (cmd.op == ikh_pkg::DOP_INSERT) begin
			bucket_mem[bkt_q] <= LW'(low_idx);
		end else if (cmd.op == ikh_pkg::DOP_UNLINK && prev_q >= LW'(NODES)) begin
			bucket_mem[bkt_q] <= link_rd_q;
		end
		bkt_rd_q <= bucket_mem[bkt_q];
	end

	// Node keys
	always_ff @(posedge clk) begin
		if (cmd.op == ikh_pkg::DOP_INSERT) begin
			key_mem[low_idx] <= op_q.key;
		end
		key_rd_q <= key_mem[cur_idx];
	end

	// Node values
	always_ff @(posedge clk) begin
		if (cmd.op == ikh_pkg::DOP_INSERT) begin
			val_mem[low_idx] <= op_q.value;
		end else if (cmd.op == ikh_pkg::DOP_OVERWRITE) begin
			val_mem[cur_idx] <= op_q.value;
		end
		val_rd_q <= val_mem[cur_idx];
	end

	// Node links
	always_ff @(posedge clk) begin
		if (cmd.op == ikh_pkg::DOP_INSERT) begin
			link_mem[low_idx] <= bkt_rd_q;
		end else if (cmd.op == ikh_pkg::DOP_UNLINK && prev_q < LW'(NODES)) begin
			link_mem[prev_idx] <= link_rd_q;
		end
		link_rd_q <= link_mem[cur_idx];
	end

	// Free-node bitmap
	always_ff @(posedge clk) begin
		if (cmd.op == ikh_pkg::DOP_CLEAR && 32'(clr_q) < FW) begin
			free_mem[clr_q[FWW-1:0]] <= clr_mask;
		end else if (cmd.op == ikh_pkg::DOP_ALLOC) begin
			free_mem[lowfree_q[IW-1:5]] <= free_rd_q & ~(32'd1 << lowfree_q[4:0]);
		end else if (cmd.op == ikh_pkg::DOP_FREE) begin
			free_mem[cur_iw[IW-1:5]] <= free_rd_q | (32'd1 << cur_iw[4:0]);
		end
		free_rd_q <= free_mem[free_raddr];
	end

	// Control-side registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			count_q   <= '0;
			lowfree_q <= '0;
		end else begin
			case (cmd.op)
				ikh_pkg::DOP_CLEAR:     clr_q <= clr_q + CW'(1);
				ikh_pkg::DOP_INSERT:    count_q <= count_q + LW'(1);
				ikh_pkg::DOP_UNLINK:    count_q <= count_q - LW'(1);
				ikh_pkg::DOP_FREE: begin
					if (count_q == LW'(NODES - 1) || cur_iw < lowfree_q) lowfree_q <= cur_iw;
				end
				ikh_pkg::DOP_SCAN_TAKE: lowfree_q <= {scan_q, pe};
				default: ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			ikh_pkg::DOP_LOAD:      op_q <= req;
			ikh_pkg::DOP_HEAD: begin
				cur_q  <= bkt_rd_q;
				prev_q <= EMPTY;
			end
			ikh_pkg::DOP_NEXT: begin
				prev_q <= cur_q;
				cur_q  <= link_rd_q;
			end
			ikh_pkg::DOP_ALLOC:     scan_q <= lowfree_q[IW-1:5];
			ikh_pkg::DOP_SCAN_NEXT: scan_q <= scan_q + FWW'(1);
			default: ;
		endcase
		if (hash_done) bkt_q <= hash[BW-1:0];
		if (cmd.res_we) begin
			res_found_q  <= cmd.res_found;
			res_status_q <= cmd.res_status;
			res_rd_q     <= cmd.res_take_val ? val_rd_q : 64'd0;
		end
		if (cmd.out_load) begin
			rsp_q.found        <= res_found_q;
			rsp_q.read_value   <= res_rd_q;
			rsp_q.stored_count <= count_ext[7:0];
			rsp_q.status       <= res_status_q;
		end
	end

	assign stat.clr_last  = (clr_q == CW'(CL - 1));
	assign stat.hash_done = hash_done;
	assign stat.cur_valid = (cur_q < LW'(NODES));
	assign stat.key_match = (key_rd_q == op_q.key);
	assign stat.full      = (count_q == LW'(NODES));
	assign stat.scan_hit  = (free_rd_q != 32'd0);
	assign stat.command   = op_q.command;
	assign rsp            = rsp_q;

endmodule

### sv/ikh_ctrl.sv
// ----------------------------------------------------------------------------
// ikh_ctrl: sequencer of the hash table
// Clearing pass, hash wait, chain walk, update and free-bitmap upkeep, and
// the response handshake.
// ----------------------------------------------------------------------------
module ikh_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	input  ikh_pkg::ctl_stat_t stat,
	output ikh_pkg::ctl_cmd_t  cmd
);

	localparam logic [3:0] S_CLEAR    = 4'd0;
	localparam logic [3:0] S_IDLE     = 4'd1;
	localparam logic [3:0] S_HASH     = 4'd2;
	localparam logic [3:0] S_HEAD     = 4'd3;
	localparam logic [3:0] S_LOAD     = 4'd4;
	localparam logic [3:0] S_WALK     = 4'd5;
	localparam logic [3:0] S_CMP      = 4'd6;
	localparam logic [3:0] S_DFREE_RD = 4'd7;
	localparam logic [3:0] S_DFREE_WR = 4'd8;
	localparam logic [3:0] S_AFREE_RD = 4'd9;
	localparam logic [3:0] S_AFREE_WR = 4'd10;
	localparam logic [3:0] S_SCAN_RD  = 4'd11;
	localparam logic [3:0] S_SCAN_CHK = 4'd12;
	localparam logic [3:0] S_DONE     = 4'd13;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       rsp_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.op = ikh_pkg::DOP_CLEAR;
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.op  = ikh_pkg::DOP_LOAD;
					state_d = S_HASH;
				end
			end
			S_HASH: begin
				if (stat.hash_done) state_d = S_HEAD;
			end
			S_HEAD: state_d = S_LOAD;
			S_LOAD: begin
				if (stat.command == ikh_pkg::CMD_NONE) begin
					cmd.res_we = 1'b1;
					state_d    = S_DONE;
				end else begin
					cmd.op  = ikh_pkg::DOP_HEAD;
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				if (stat.cur_valid) begin
					state_d = S_CMP;
				end else begin
					cmd.res_we = 1'b1;
					state_d    = S_DONE;
					if (stat.command == ikh_pkg::CMD_LOOKUP) begin
						cmd.res_status = ikh_pkg::ST_MISSING;
					end else if (stat.command == ikh_pkg::CMD_SET) begin
						if (stat.full) begin
							cmd.res_status = ikh_pkg::ST_FULL;
						end else begin
							cmd.op  = ikh_pkg::DOP_INSERT;
							state_d = S_AFREE_RD;
						end
					end
				end
			end
			S_CMP: begin
				if (stat.key_match) begin
					cmd.res_we    = 1'b1;
					cmd.res_found = 1'b1;
					state_d       = S_DONE;
					if (stat.command == ikh_pkg::CMD_LOOKUP) begin
						cmd.res_take_val = 1'b1;
					end else if (stat.command == ikh_pkg::CMD_SET) begin
						cmd.op = ikh_pkg::DOP_OVERWRITE;
					end else begin
						cmd.op  = ikh_pkg::DOP_UNLINK;
						state_d = S_DFREE_RD;
					end
				end else begin
					cmd.op  = ikh_pkg::DOP_NEXT;
					state_d = S_WALK;
				end
			end
			S_DFREE_RD: begin
				cmd.fsel = ikh_pkg::FSEL_CUR;
				state_d  = S_DFREE_WR;
			end
			S_DFREE_WR: begin
				cmd.fsel = ikh_pkg::FSEL_CUR;
				cmd.op   = ikh_pkg::DOP_FREE;
				state_d  = S_DONE;
			end
			S_AFREE_RD: begin
				cmd.fsel = ikh_pkg::FSEL_LOW;
				state_d  = S_AFREE_WR;
			end
			S_AFREE_WR: begin
				cmd.fsel = ikh_pkg::FSEL_LOW;
				cmd.op   = ikh_pkg::DOP_ALLOC;
				state_d  = stat.full ? S_DONE : S_SCAN_RD;
			end
			S_SCAN_RD: begin
				cmd.fsel = ikh_pkg::FSEL_SCAN;
				state_d  = S_SCAN_CHK;
			end
			S_SCAN_CHK: begin
				cmd.fsel = ikh_pkg::FSEL_SCAN;
				if (stat.scan_hit) begin
					cmd.op  = ikh_pkg::DOP_SCAN_TAKE;
					state_d = S_DONE;
				end else begin
					cmd.op  = ikh_pkg::DOP_SCAN_NEXT;
					state_d = S_SCAN_RD;
				end
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

endmodule

### sv/integer_key_hash_table_core.sv
// ----------------------------------------------------------------------------
// integer_key_hash_table_core: chained hash table, 64-bit keys and values
// Lookup, set and delete over a fixed node pool with bucket chains.
// ----------------------------------------------------------------------------
// One transaction at a time. After reset the block runs a clearing pass over
// the bucket heads and the free-node bitmap with req_ready low. A transaction
// then hashes its key, one 32x32 partial product per cycle on a shared
// multiplier, fetches the bucket head and walks the chain; each chain node
// costs one node-memory read and one key compare. The unused command skips
// the walk. A set that adds a new key then marks its node used and scans the
// free-bitmap words for the next free node (no scan once the pool is full); a
// delete hit marks its node free. A response not yet taken holds the next
// finished transaction until it is taken. The next request is accepted while
// an earlier response still waits in the output register.
module integer_key_hash_table_core #(
	parameter int BUCKETS = ikh_pkg::BUCKETS_DEF,
	parameter int NODES   = ikh_pkg::NODES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  ikh_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output ikh_pkg::rsp_t rsp
);

	ikh_pkg::ctl_cmd_t  cmd;
	ikh_pkg::ctl_stat_t stat;

	// Sequencer: walks each transaction through hash, chain walk and update
	ikh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Storage, pointers and response register
	ikh_datapath #(
		.BUCKETS (BUCKETS),
		.NODES   (NODES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

	// Hold off new requests until the current transaction is done
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request accepted while a transaction is in flight");

	// Start a transaction only on an accepted request
	a_load_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == ikh_pkg::DOP_LOAD) |-> (req_valid && req_ready))
		else $error("transaction started without an accepted request");

	// A missing key reports nothing found and a zero value
	a_miss_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == ikh_pkg::ST_MISSING) |->
		(!rsp.found && rsp.read_value == 64'd0))
		else $error("missing-key response carries data");

	// A hit always reports ok status
	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.found) |-> (rsp.status == ikh_pkg::ST_OK))
		else $error("hit reported with an error status");

endmodule
